/* hdl/afjb_pkg.sv */
// shared types and constants for the audio frame jitter buffer
package afjb_pkg;

	// default sizes of the frame store and the frame ring
	localparam int DEF_MAX_FRAME_LEN   = 64;
	localparam int DEF_MAX_RING_FRAMES = 16;

	// register reset values
	localparam logic [6:0] FRAME_LENGTH_RST  = 7'd64;
	localparam logic [4:0] RING_CAPACITY_RST = 5'd16;

	// register indexes, taken from paddr[2]
	localparam logic REG_FRAME_LENGTH  = 1'b0;
	localparam logic REG_RING_CAPACITY = 1'b1;

	// input transaction kinds
	typedef enum logic [1:0] {
		KIND_PUSH  = 2'd0,
		KIND_POP   = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_POP_RD,
		ST_POP_LD,
		ST_POP_OUT
	} seq_state_t;

	// configuration handed from the register block to the core
	typedef struct packed {
		logic [6:0] frame_length;
		logic [4:0] ring_capacity;
		logic       clear;
	} ctl_t;

endpackage

/* hdl/audio_frame_jitter_buffer.sv */
// top level of the audio frame jitter buffer: register port and core
//
// Input stream (s_*): s_tuser carries the kind (push, pop, clear), s_tdata the
// sample of a push. A push stores one sample in the partial frame; when the
// frame is complete it is copied into the ring, dropping the oldest frame if
// the ring is full. A pop streams one frame on m_*, one transaction per sample,
// with m_tlast on the final sample; on an empty ring it sends zeros with the
// underrun flag in m_tuser. A clear empties the ring and the partial frame.
// Sequencing: a push is accepted while idle; a frame-completing push is then
// followed by the copy through the shared address unit, a ram read and a ram
// write for each sample. A pop is accepted, then does a ram read, load and
// output for each sample, waiting whenever the receiver stalls, and s_tready
// stays low until the last sample is taken. A stalled receiver holds the output
// register and simply stretches the pop.
// Registers (APB): frame_length at 0, ring_capacity at 4; a write also empties
// the buffer. Reset clears the pointers and counts, restores the register
// defaults (64 samples, 16 frames) and leaves the sample stores unwritten.
module audio_frame_jitter_buffer
	import afjb_pkg::*;
#(
	parameter int MAX_FRAME_LEN   = DEF_MAX_FRAME_LEN,
	parameter int MAX_RING_FRAMES = DEF_MAX_RING_FRAMES
) (
	input  logic        clk,
	input  logic        arst_n,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample
	input  logic [1:0]  s_tuser,   // [1:0] kind
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [15:0] out_sample, [20:16] frames_queued, rest zero
	output logic        m_tlast,
	output logic        m_tuser    // [0] underrun
);

	logic [6:0]  frame_length_q;
	logic [4:0]  ring_capacity_q;
	logic        cfg_wr;
	ctl_t        ctl;
	logic [15:0] out_sample;
	logic [4:0]  out_queued;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q  <= FRAME_LENGTH_RST;
			ring_capacity_q <= RING_CAPACITY_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_FRAME_LENGTH) begin
				frame_length_q <= pwdata[6:0];
			end else begin
				ring_capacity_q <= pwdata[4:0];
			end
		end
	end

	// register readback
	always_comb begin
		if (paddr[2] == REG_RING_CAPACITY) begin
			prdata = {27'd0, ring_capacity_q};
		end else begin
			prdata = {25'd0, frame_length_q};
		end
	end

	// any register write empties the buffer
	assign ctl.frame_length  = frame_length_q;
	assign ctl.ring_capacity = ring_capacity_q;
	assign ctl.clear         = cfg_wr;

	afjb_core #(
		.MAX_FRAME_LEN   (MAX_FRAME_LEN),
		.MAX_RING_FRAMES (MAX_RING_FRAMES)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_kind      (s_tuser),
		.in_sample    (s_tdata),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_sample   (out_sample),
		.out_last     (m_tlast),
		.out_underrun (m_tuser),
		.out_queued   (out_queued)
	);

	// pack the result transaction
	assign m_tdata = {3'd0, out_queued, out_sample};

endmodule

/* hdl/afjb_ram.sv */
// generic simple dual-port ram with registered read
module afjb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/afjb_core.sv */
// sequencer, slot pointers and shared address unit of the jitter buffer
module afjb_core
	import afjb_pkg::*;
#(
	parameter int MAX_FRAME_LEN   = DEF_MAX_FRAME_LEN,
	parameter int MAX_RING_FRAMES = DEF_MAX_RING_FRAMES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  in_kind,
	input  logic [15:0] in_sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_sample,
	output logic        out_last,
	output logic        out_underrun,
	output logic [4:0]  out_queued
);

	localparam int LEN_W   = $clog2(MAX_FRAME_LEN + 1);
	localparam int IDX_W   = (MAX_FRAME_LEN > 1) ? $clog2(MAX_FRAME_LEN) : 1;
	localparam int SLOT_W  = (MAX_RING_FRAMES > 1) ? $clog2(MAX_RING_FRAMES) : 1;
	localparam int CNT_W   = $clog2(MAX_RING_FRAMES + 1);
	localparam int DEPTH   = MAX_FRAME_LEN * MAX_RING_FRAMES;
	localparam int RADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	seq_state_t state_q, state_d;

	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   pcount_q;
	logic [SLOT_W-1:0]  rd_slot_q, wr_slot_q;
	logic [CNT_W-1:0]   queued_q;
	logic [RADDR_W-1:0] base_q;
	logic               underrun_q;
	logic [4:0]         queued_out_q;
	logic [15:0]        out_sample_q;
	logic               out_last_q;

	logic [LEN_W-1:0]   eff_len;
	logic [CNT_W-1:0]   eff_cap;
	logic [IDX_W-1:0]   last_idx;
	logic               at_last;
	logic               accept;
	logic               commit;
	logic               ring_full;
	logic [SLOT_W-1:0]  rd_slot_inc, wr_slot_inc;
	logic [RADDR_W-1:0] ring_addr;
	logic               part_we, ring_we;
	logic [15:0]        part_rdata, ring_rdata;
	kind_t              kind;

	// clamp the registers to the supported range
	always_comb begin
		if (ctl.frame_length == 7'd0) begin
			eff_len = LEN_W'(1);
		end else if (32'(ctl.frame_length) > MAX_FRAME_LEN) begin
			eff_len = LEN_W'(MAX_FRAME_LEN);
		end else begin
			eff_len = LEN_W'(ctl.frame_length);
		end
		if (ctl.ring_capacity == 5'd0) begin
			eff_cap = CNT_W'(1);
		end else if (32'(ctl.ring_capacity) > MAX_RING_FRAMES) begin
			eff_cap = CNT_W'(MAX_RING_FRAMES);
		end else begin
			eff_cap = CNT_W'(ctl.ring_capacity);
		end
	end

	// frame position, slot wrap and commit decisions
	assign kind        = kind_t'(in_kind);
	assign last_idx    = IDX_W'(eff_len - LEN_W'(1));
	assign at_last     = (idx_q == last_idx);
	assign accept      = in_valid && in_ready;
	assign commit      = (LEN_W'(pcount_q) + LEN_W'(1)) >= eff_len;
	assign ring_full   = queued_q >= eff_cap;
	assign rd_slot_inc = ((CNT_W'(rd_slot_q) + CNT_W'(1)) >= eff_cap) ?
		'0 : rd_slot_q + SLOT_W'(1);
	assign wr_slot_inc = ((CNT_W'(wr_slot_q) + CNT_W'(1)) >= eff_cap) ?
		'0 : wr_slot_q + SLOT_W'(1);

	// shared address adder for frame copy and frame readout
	assign ring_addr = base_q + RADDR_W'(idx_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (kind)
						KIND_PUSH: begin
							if (commit) begin
								state_d = ST_COPY_RD;
							end
						end
						KIND_POP: state_d = ST_POP_RD;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_COPY_RD: state_d = ST_COPY_WR;
			ST_COPY_WR: state_d = at_last ? ST_IDLE : ST_COPY_RD;
			ST_POP_RD:  state_d = ST_POP_LD;
			ST_POP_LD:  state_d = ST_POP_OUT;
			ST_POP_OUT: begin
				if (out_ready) begin
					state_d = at_last ? ST_IDLE : ST_POP_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		out_valid = (state_q == ST_POP_OUT);
		ring_we   = (state_q == ST_COPY_WR);
		part_we   = (state_q == ST_IDLE) && in_valid && (kind == KIND_PUSH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// pointers, counts and sample index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			pcount_q  <= '0;
			rd_slot_q <= '0;
			wr_slot_q <= '0;
			queued_q  <= '0;
		end else if (ctl.clear) begin
			pcount_q  <= '0;
			rd_slot_q <= '0;
			wr_slot_q <= '0;
			queued_q  <= '0;
		end else if (accept) begin
			idx_q <= '0;
			case (kind)
				KIND_PUSH: begin
					if (commit) begin
						pcount_q  <= '0;
						wr_slot_q <= wr_slot_inc;
						if (ring_full) begin
							// oldest frame is dropped to make room
							rd_slot_q <= rd_slot_inc;
							queued_q  <= eff_cap;
						end else begin
							queued_q <= queued_q + CNT_W'(1);
						end
					end else begin
						pcount_q <= pcount_q + IDX_W'(1);
					end
				end
				KIND_POP: begin
					if (queued_q != '0) begin
						rd_slot_q <= rd_slot_inc;
						queued_q  <= queued_q - CNT_W'(1);
					end
				end
				KIND_CLEAR: begin
					pcount_q  <= '0;
					rd_slot_q <= '0;
					wr_slot_q <= '0;
					queued_q  <= '0;
				end
				default: begin
				end
			endcase
		end else if ((state_q == ST_COPY_WR) && !at_last) begin
			idx_q <= idx_q + IDX_W'(1);
		end else if ((state_q == ST_POP_OUT) && out_ready && !at_last) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// frame base address, pop flags and output register
	always_ff @(posedge clk) begin
		if (accept && (kind == KIND_PUSH) && commit) begin
			base_q <= RADDR_W'(32'(wr_slot_q) * MAX_FRAME_LEN);
		end
		if (accept && (kind == KIND_POP)) begin
			base_q       <= RADDR_W'(32'(rd_slot_q) * MAX_FRAME_LEN);
			underrun_q   <= (queued_q == '0);
			queued_out_q <= (queued_q == '0) ? 5'd0 : 5'(32'(queued_q) - 1);
		end
		if (state_q == ST_POP_LD) begin
			out_sample_q <= underrun_q ? 16'd0 : ring_rdata;
			out_last_q   <= at_last;
		end
	end

	assign out_sample   = out_sample_q;
	assign out_last     = out_last_q;
	assign out_underrun = underrun_q;
	assign out_queued   = queued_out_q;

	// partial frame store
	afjb_ram #(
		.WIDTH(16),
		.DEPTH(MAX_FRAME_LEN)
	) u_part_ram (
		.clk   (clk),
		.we    (part_we),
		.waddr (pcount_q),
		.wdata (in_sample),
		.raddr (idx_q),
		.rdata (part_rdata)
	);

	// ring of frames
	afjb_ram #(
		.WIDTH(16),
		.DEPTH(DEPTH)
	) u_ring_ram (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_addr),
		.wdata (part_rdata),
		.raddr (ring_addr),
		.rdata (ring_rdata)
	);

endmodule
